// ===== rtl/periodic_callback_timer_table_macros.svh =====
// assertion helpers for the timer table checker
`ifndef PERIODIC_CALLBACK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_CALLBACK_TIMER_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCTT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PCTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pctt_pkg.sv =====
package pctt_pkg;

    // input action codes
    localparam logic [2:0] ACT_FAST_TICK = 3'd0;
    localparam logic [2:0] ACT_SLOW_TICK = 3'd1;
    localparam logic [2:0] ACT_REG       = 3'd2;
    localparam logic [2:0] ACT_UNREG     = 3'd3;
    localparam logic [2:0] ACT_RESET     = 3'd4;
    localparam logic [2:0] ACT_REG_DIR   = 3'd5;
    localparam logic [2:0] ACT_UNREG_DIR = 3'd6;
    localparam logic [2:0] ACT_RESET_DIR = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_QFIRE  = 2'd1;
    localparam logic [1:0] KIND_DFIRE  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // table selectors
    localparam logic [1:0] TBL_FAST   = 2'd0;
    localparam logic [1:0] TBL_SLOW   = 2'd1;
    localparam logic [1:0] TBL_DIRECT = 2'd2;

    // queued periods from this many ms upwards go to the slow table
    localparam logic [15:0] SLOW_MS_MIN = 16'd1000;

    localparam logic [6:0] PERIOD_MAX = 7'd127;

    typedef struct packed {
        logic [15:0] handler;
        logic [6:0]  period;
        logic [6:0]  count;
    } slot_t;

    typedef struct packed {
        logic slow;
        logic sat;
    } per_mode_t;

endpackage

// ===== rtl/pctt_period.sv =====
module pctt_period (
    input  logic               aclk,
    input  logic [15:0]        ms,
    input  pctt_pkg::per_mode_t mode,
    output logic [6:0]         period
);

    // x/20 = (x>>2)/5 and x/1000 = (x>>3)/125, each by reciprocal and one fix-up
    localparam logic [13:0] RECIP_5   = 14'd13107;
    localparam logic [13:0] RECIP_125 = 14'd8388;

    logic [16:0] sum_fast;
    logic [16:0] sum_slow;
    logic [14:0] op_a;
    logic [13:0] op_b;
    logic [28:0] prod;
    logic [12:0] q_est;

    logic [12:0] q_reg;
    logic [14:0] d_reg;
    pctt_pkg::per_mode_t mode_reg;

    logic [16:0] divisor;
    logic [16:0] rem;
    logic [12:0] q_fix;
    logic [6:0]  period_reg;

    always_comb begin
        sum_fast = {1'b0, ms} + 17'd10;
        sum_slow = {1'b0, ms} + 17'd500;
        op_a     = mode.slow ? {1'b0, sum_slow[16:3]} : sum_fast[16:2];
        op_b     = mode.slow ? RECIP_125 : RECIP_5;
        prod     = 29'(op_a) * 29'(op_b);
        q_est    = mode.slow ? 13'(prod >> 20) : 13'(prod >> 16);
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_est;
        d_reg    <= op_a;
        mode_reg <= mode;
    end

    always_comb begin
        divisor = mode_reg.slow ? 17'd125 : 17'd5;
        rem     = 17'(d_reg) - 17'(17'(q_reg) * divisor);
        q_fix   = (rem >= divisor) ? q_reg + 13'd1 : q_reg;
    end

    always_ff @(posedge aclk) begin
        if (mode_reg.sat && (q_fix > 13'(pctt_pkg::PERIOD_MAX))) begin
            period_reg <= pctt_pkg::PERIOD_MAX;
        end else begin
            period_reg <= q_fix[6:0];
        end
    end

    assign period = period_reg;

endmodule

// ===== rtl/periodic_callback_timer_table.sv =====
// per item: a refused (zero) id goes straight to status; direct commands walk the direct
// table, queued unregister or reset the slow then fast table, register the period states,
// its table and the write state, fast tick the fast then direct table, slow tick the slow
// table; one item at a time, the next word is taken once the closing word is out; each
// slot is read then updated; a fire word stuck on the result port holds the walk until taken
// reset: synchronous active-low; all valid flags clear at once, ready the cycle after reset
module periodic_callback_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // handler_id[15:0], period_ms[31:16]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fired_id[15:0], slot_index[19:16], ok[20], zero[23:21]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int ENTRIES = 3 * SLOTS;
    localparam int AW      = $clog2(ENTRIES);
    localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PER1 = 4'd1;
    localparam logic [3:0] ST_PER2 = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_EV   = 4'd4;
    localparam logic [3:0] ST_WR   = 4'd5;
    localparam logic [3:0] ST_STAT = 4'd6;
    localparam logic [3:0] ST_DONE = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    act_reg, act_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   ms_reg, ms_next;
    logic [1:0]    tbl_reg, tbl_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          res_ok_reg, res_ok_next;
    logic [3:0]    res_slot_reg, res_slot_next;

    logic          m_tvalid_reg;
    logic [1:0]    m_kind_reg;
    logic [15:0]   m_id_reg;
    logic [3:0]    m_slot_reg;
    logic          m_ok_reg;
    logic          m_last_reg;

    // slot memory
    pctt_pkg::slot_t     mem [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    pctt_pkg::slot_t     rd_reg;
    logic                rvalid_reg;

    logic                mem_re;
    logic                mem_we;
    pctt_pkg::slot_t     mem_wd;
    logic [AW-1:0]       addr;
    logic [IW-1:0]       sel_idx;
    logic [IW+3:0]       sel_ext;
    logic [3:0]          slot4;

    logic [15:0]         cur_h;
    logic [6:0]          cur_p;
    logic [6:0]          cur_c;
    logic [6:0]          cnt_inc;

    logic                emit;
    logic [1:0]          e_kind;
    logic [15:0]         e_id;
    logic [3:0]          e_slot;
    logic                e_ok;
    logic                e_last;

    logic                out_free;
    logic                accept;
    logic                idx_end;
    logic [6:0]          period;
    pctt_pkg::per_mode_t per_mode;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign idx_end  = (idx_reg == IDX_LAST);

    assign per_mode.slow = (tbl_reg == pctt_pkg::TBL_SLOW);
    assign per_mode.sat  = (tbl_reg == pctt_pkg::TBL_DIRECT);

    pctt_period u_period (
        .aclk   (aclk),
        .ms     (ms_reg),
        .mode   (per_mode),
        .period (period)
    );

    assign addr    = AW'(AW'(tbl_reg) * AW'(SLOTS)) + AW'(sel_idx);
    assign sel_ext = {4'b0000, sel_idx};
    assign slot4   = sel_ext[3:0];

    // a never-written slot reads as free
    assign cur_h   = rvalid_reg ? rd_reg.handler : 16'd0;
    assign cur_p   = rvalid_reg ? rd_reg.period : 7'd0;
    assign cur_c   = rvalid_reg ? rd_reg.count : 7'd0;
    assign cnt_inc = cur_c + 7'd1;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg     <= mem[addr];
            rvalid_reg <= valid_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        id_next       = id_reg;
        ms_next       = ms_reg;
        tbl_next      = tbl_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        sel_idx       = idx_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_wd        = rd_reg;
        emit          = 1'b0;
        e_kind        = pctt_pkg::KIND_STATUS;
        e_id          = 16'd0;
        e_slot        = 4'd0;
        e_ok          = 1'b1;
        e_last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_next  = s_tuser;
                    id_next   = s_tdata[15:0];
                    ms_next   = s_tdata[31:16];
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    if (s_tuser == pctt_pkg::ACT_FAST_TICK) begin
                        tbl_next   = pctt_pkg::TBL_FAST;
                        state_next = ST_RD;
                    end else if (s_tuser == pctt_pkg::ACT_SLOW_TICK) begin
                        tbl_next   = pctt_pkg::TBL_SLOW;
                        state_next = ST_RD;
                    end else if (s_tdata[15:0] == 16'd0) begin
                        res_ok_next   = 1'b0;
                        res_slot_next = 4'd0;
                        state_next    = ST_STAT;
                    end else begin
                        case (s_tuser)
                            pctt_pkg::ACT_REG: begin
                                tbl_next   = (s_tdata[31:16] >= pctt_pkg::SLOW_MS_MIN) ?
                                             pctt_pkg::TBL_SLOW : pctt_pkg::TBL_FAST;
                                state_next = ST_PER1;
                            end
                            pctt_pkg::ACT_REG_DIR: begin
                                tbl_next   = pctt_pkg::TBL_DIRECT;
                                state_next = ST_PER1;
                            end
                            pctt_pkg::ACT_UNREG, pctt_pkg::ACT_RESET: begin
                                tbl_next   = pctt_pkg::TBL_SLOW;
                                state_next = ST_RD;
                            end
                            default: begin
                                tbl_next   = pctt_pkg::TBL_DIRECT;
                                state_next = ST_RD;
                            end
                        endcase
                    end
                end
            end
            ST_PER1: begin
                state_next = ST_PER2;
            end
            ST_PER2: begin
                state_next = ST_RD;
            end
            ST_RD: begin
                mem_re     = 1'b1;
                state_next = ST_EV;
            end
            ST_EV: begin
                if (act_reg inside {pctt_pkg::ACT_FAST_TICK, pctt_pkg::ACT_SLOW_TICK}) begin
                    if ((cur_h != 16'd0) && (cnt_inc >= cur_p) && !out_free) begin
                        state_next = ST_EV;
                    end else begin
                        if (cur_h != 16'd0) begin
                            mem_we       = 1'b1;
                            mem_wd.count = cnt_inc;
                            if (cnt_inc >= cur_p) begin
                                mem_wd.count = 7'd0;
                                emit   = 1'b1;
                                e_kind = (tbl_reg == pctt_pkg::TBL_DIRECT) ?
                                         pctt_pkg::KIND_DFIRE : pctt_pkg::KIND_QFIRE;
                                e_id   = cur_h;
                                e_slot = slot4;
                                e_last = 1'b0;
                            end
                        end
                        if (!idx_end) begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_RD;
                        end else if ((act_reg == pctt_pkg::ACT_FAST_TICK) &&
                                     (tbl_reg == pctt_pkg::TBL_FAST)) begin
                            tbl_next   = pctt_pkg::TBL_DIRECT;
                            idx_next   = '0;
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end else if (act_reg inside {pctt_pkg::ACT_REG, pctt_pkg::ACT_REG_DIR}) begin
                    if ((cur_h == id_reg) && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_reg;
                    end
                    if ((cur_h == 16'd0) && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (!idx_end) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_WR;
                    end
                end else begin
                    if (cur_h == id_reg) begin
                        mem_we = 1'b1;
                        if (act_reg inside {pctt_pkg::ACT_UNREG, pctt_pkg::ACT_UNREG_DIR}) begin
                            mem_wd.handler = 16'd0;
                        end else begin
                            mem_wd.count = 7'd0;
                        end
                        res_ok_next   = 1'b1;
                        res_slot_next = slot4;
                        state_next    = ST_STAT;
                    end else if (!idx_end) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end else if (tbl_reg == pctt_pkg::TBL_SLOW) begin
                        // queued search falls through from the slow to the fast table
                        tbl_next   = pctt_pkg::TBL_FAST;
                        idx_next   = '0;
                        state_next = ST_RD;
                    end else begin
                        res_ok_next   = 1'b0;
                        res_slot_next = 4'd0;
                        state_next    = ST_STAT;
                    end
                end
            end
            ST_WR: begin
                sel_idx = hit_reg ? hit_idx_reg : free_idx_reg;
                if (hit_reg || free_reg) begin
                    mem_we         = 1'b1;
                    mem_wd.handler = id_reg;
                    mem_wd.period  = period;
                    mem_wd.count   = 7'd0;
                    res_ok_next    = 1'b1;
                    res_slot_next  = slot4;
                end else begin
                    res_ok_next   = 1'b0;
                    res_slot_next = 4'd0;
                end
                state_next = ST_STAT;
            end
            ST_STAT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = pctt_pkg::KIND_STATUS;
                    e_id       = id_reg;
                    e_slot     = res_slot_reg;
                    e_ok       = res_ok_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = pctt_pkg::KIND_TICK;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        id_reg       <= id_next;
        ms_reg       <= ms_next;
        tbl_reg      <= tbl_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        if (emit) begin
            m_kind_reg <= e_kind;
            m_id_reg   <= e_id;
            m_slot_reg <= e_slot;
            m_ok_reg   <= e_ok;
            m_last_reg <= e_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_ok_reg, m_slot_reg, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/pctt_checker.sv =====
`include "periodic_callback_timer_table_macros.svh"

module pctt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // one item at a time: the block is busy right after taking a word
    `PCTT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready stayed high after an accepted word")

    // a stalled result word holds
    `PCTT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

    // status and tick-done words close an item
    `PCTT_ASSERT_SAME(a_close_last, aclk, aresetn, m_tvalid && ((m_tuser == pctt_pkg::KIND_STATUS) || (m_tuser == pctt_pkg::KIND_TICK)), m_tlast, "closing word without tlast")

    // fire words never close an item, always carry ok and a live id
    `PCTT_ASSERT_SAME(a_fire_body, aclk, aresetn, m_tvalid && ((m_tuser == pctt_pkg::KIND_QFIRE) || (m_tuser == pctt_pkg::KIND_DFIRE)), !m_tlast && m_tdata[20] && (m_tdata[15:0] != 16'd0), "malformed fire word")

endmodule

bind periodic_callback_timer_table pctt_checker u_pctt_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS = 16;
    localparam int TAIL_CYCLES = 4 * SLOTS + 8;
    localparam int LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [3:0]  slot;
        logic        ok;
        logic        last;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // handler_id[15:0], period_ms[31:16]
    logic [2:0]  s_tuser = '0;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // fired_id[15:0], slot_index[19:16], ok[20], zero[23:21]
    logic [1:0]  m_tuser;        // kind[1:0]
    logic        m_tlast;

    // shadow copy of the three slot tables
    logic [15:0] timer_handler [3*SLOTS];
    logic [6:0]  timer_period  [3*SLOTS];
    logic [6:0]  timer_count   [3*SLOTS];

    outcome_t pending_outcomes [$];
    bit       steady = 1'b0;
    int       mismatches = 0;
    int       words_sent = 0;
    int       words_checked = 0;
    int       fires_seen = 0;
    int       cycles = 0;

    periodic_callback_timer_table #(.SLOTS(SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_outcome(logic [1:0] kind, logic [15:0] id, logic [3:0] slot,
                                         logic ok, logic last);
        outcome_t o;
        o.kind = kind;
        o.id   = id;
        o.slot = slot;
        o.ok   = ok;
        o.last = last;
        pending_outcomes.push_back(o);
    endfunction

    function automatic int find_slot(int tbl, logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (timer_handler[tbl*SLOTS + i] == id)
                return i;
        return -1;
    endfunction

    function automatic void advance_table(int tbl, logic [1:0] kind);
        int e;
        for (int i = 0; i < SLOTS; i++) begin
            e = tbl * SLOTS + i;
            if (timer_handler[e] != 16'd0) begin
                timer_count[e] = timer_count[e] + 7'd1;
                if (timer_count[e] >= timer_period[e]) begin
                    push_outcome(kind, timer_handler[e], 4'(i), 1'b1, 1'b0);
                    timer_count[e] = '0;
                end
            end
        end
    endfunction

    // same id in the table is updated, otherwise the first free slot is taken
    function automatic int claim_slot(int tbl, logic [15:0] id, logic [6:0] per);
        int i;
        i = find_slot(tbl, id);
        if (i < 0)
            i = find_slot(tbl, 16'd0);
        if (i >= 0) begin
            timer_handler[tbl*SLOTS + i] = id;
            timer_period[tbl*SLOTS + i]  = per;
            timer_count[tbl*SLOTS + i]   = '0;
        end
        return i;
    endfunction

    function automatic void predict_outcomes(logic [2:0] act, logic [15:0] id, logic [15:0] ms);
        int          slot;
        int          tbl;
        int unsigned fast_ticks;
        int unsigned slow_ticks;
        slot = -1;
        tbl = pctt_pkg::TBL_DIRECT;
        fast_ticks = (32'(ms) + 10) / 20;
        slow_ticks = (32'(ms) + 500) / 1000;
        if (act == pctt_pkg::ACT_FAST_TICK || act == pctt_pkg::ACT_SLOW_TICK) begin
            if (act == pctt_pkg::ACT_FAST_TICK) begin
                advance_table(pctt_pkg::TBL_FAST, pctt_pkg::KIND_QFIRE);
                advance_table(pctt_pkg::TBL_DIRECT, pctt_pkg::KIND_DFIRE);
            end else begin
                advance_table(pctt_pkg::TBL_SLOW, pctt_pkg::KIND_QFIRE);
            end
            push_outcome(pctt_pkg::KIND_TICK, 16'd0, 4'd0, 1'b1, 1'b1);
            return;
        end
        if (id != 16'd0) begin
            case (act)
                pctt_pkg::ACT_REG: begin
                    if (ms >= pctt_pkg::SLOW_MS_MIN)
                        slot = claim_slot(pctt_pkg::TBL_SLOW, id, 7'(slow_ticks));
                    else
                        slot = claim_slot(pctt_pkg::TBL_FAST, id, 7'(fast_ticks));
                end
                pctt_pkg::ACT_REG_DIR: begin
                    slot = claim_slot(pctt_pkg::TBL_DIRECT, id,
                                      (fast_ticks > pctt_pkg::PERIOD_MAX) ?
                                      pctt_pkg::PERIOD_MAX : 7'(fast_ticks));
                end
                pctt_pkg::ACT_UNREG, pctt_pkg::ACT_RESET: begin
                    // slow table is searched first
                    tbl = pctt_pkg::TBL_SLOW;
                    slot = find_slot(tbl, id);
                    if (slot < 0) begin
                        tbl = pctt_pkg::TBL_FAST;
                        slot = find_slot(tbl, id);
                    end
                end
                default: begin
                    slot = find_slot(tbl, id);
                end
            endcase
            if (slot >= 0 && act != pctt_pkg::ACT_REG && act != pctt_pkg::ACT_REG_DIR) begin
                if (act == pctt_pkg::ACT_UNREG || act == pctt_pkg::ACT_UNREG_DIR)
                    timer_handler[tbl*SLOTS + slot] = '0;
                else
                    timer_count[tbl*SLOTS + slot] = '0;
            end
        end
        push_outcome(pctt_pkg::KIND_STATUS, id, (slot >= 0) ? 4'(slot) : 4'd0, slot >= 0, 1'b1);
    endfunction

    task automatic send_word(input logic [2:0] act, input logic [15:0] id, input logic [15:0] ms);
        int gap;
        gap = 0;
        if (!steady) begin
            while (gap < 8 && $urandom_range(0, 99) < 26)
                gap++;
            // now and then hold off for a longer random gap
            if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(1, 4 * SLOTS);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {ms, id};
        do @(posedge aclk); while (!s_tready);
        predict_outcomes(act, id, ms);
        words_sent++;
    endtask

    task automatic send_random_word(input int reg_pct, input int id_pool);
        logic [2:0]  act;
        logic [15:0] id;
        logic [15:0] ms;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = pctt_pkg::ACT_FAST_TICK;
        else if (pick < 38)
            act = pctt_pkg::ACT_SLOW_TICK;
        else if (pick < 38 + reg_pct)
            act = $urandom_range(0, 1) ? pctt_pkg::ACT_REG : pctt_pkg::ACT_REG_DIR;
        else begin
            case ($urandom_range(0, 3))
                0:       act = pctt_pkg::ACT_UNREG;
                1:       act = pctt_pkg::ACT_RESET;
                2:       act = pctt_pkg::ACT_UNREG_DIR;
                default: act = pctt_pkg::ACT_RESET_DIR;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 4)
            id = 16'd0;
        else if (pick < 12)
            id = 16'($urandom);
        else
            id = 16'($urandom_range(1, id_pool));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            ms = 16'($urandom_range(0, 100));
        else if (pick < 65)
            ms = 16'($urandom_range(0, 999));
        else if (pick < 85)
            ms = 16'($urandom_range(1000, 3499));
        else
            ms = 16'($urandom);
        send_word(act, id, ms);
    endtask

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got kind %0d id %0h",
                         $time, m_tuser, m_tdata[15:0]);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (want.kind == pctt_pkg::KIND_QFIRE || want.kind == pctt_pkg::KIND_DFIRE)
                    fires_seen++;
                check_field("kind", 16'(want.kind), 16'(m_tuser));
                check_field("fired_id", want.id, m_tdata[15:0]);
                check_field("slot_index", 16'(want.slot), 16'(m_tdata[19:16]));
                check_field("ok", 16'(want.ok), 16'(m_tdata[20]));
                check_field("last", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: timed out with %0d results outstanding", $time, pending_outcomes.size());
        $display("FAIL periodic_callback_timer_table");
        $finish;
    end

    task automatic test_refused_ids();
        send_word(pctt_pkg::ACT_REG, 16'd0, 16'd40);
        send_word(pctt_pkg::ACT_UNREG, 16'd0, 16'd0);
        send_word(pctt_pkg::ACT_RESET, 16'd0, 16'hFFFF);
        send_word(pctt_pkg::ACT_REG_DIR, 16'd0, 16'd40);
        send_word(pctt_pkg::ACT_UNREG_DIR, 16'd0, 16'd0);
        send_word(pctt_pkg::ACT_RESET_DIR, 16'd0, 16'hFFFF);
    endtask

    task automatic test_period_rounding();
        send_word(pctt_pkg::ACT_REG, 16'hFFFF, 16'd0);       // zero period, fires every tick
        send_word(pctt_pkg::ACT_REG, 16'd2, 16'd999);        // top of the fast range
        send_word(pctt_pkg::ACT_REG, 16'd3, 16'd1000);       // bottom of the slow range
        send_word(pctt_pkg::ACT_REG, 16'd4, 16'hFFFF);       // longest slow period
        send_word(pctt_pkg::ACT_REG_DIR, 16'd5, 16'hFFFF);   // saturates
        send_word(pctt_pkg::ACT_REG_DIR, 16'd6, 16'd9);      // rounds down to zero
        send_word(pctt_pkg::ACT_FAST_TICK, 16'hFFFF, 16'hFFFF);
        send_word(pctt_pkg::ACT_SLOW_TICK, 16'd0, 16'd0);
        send_word(pctt_pkg::ACT_FAST_TICK, 16'd0, 16'd0);
        send_word(pctt_pkg::ACT_RESET, 16'hFFFF, 16'd0);
    endtask

    task automatic test_shared_queued_id();
        send_word(pctt_pkg::ACT_REG, 16'd7, 16'd20);
        send_word(pctt_pkg::ACT_REG, 16'd7, 16'd2000);       // same id lands in the slow table too
        send_word(pctt_pkg::ACT_REG, 16'd7, 16'd40);         // updates the fast slot in place
        send_word(pctt_pkg::ACT_SLOW_TICK, 16'd0, 16'd0);
        send_word(pctt_pkg::ACT_UNREG, 16'd7, 16'd0);        // slow copy goes first
        send_word(pctt_pkg::ACT_RESET, 16'd7, 16'd0);
        send_word(pctt_pkg::ACT_UNREG, 16'd7, 16'd0);
        send_word(pctt_pkg::ACT_UNREG, 16'd7, 16'd0);        // nothing left to find
        send_word(pctt_pkg::ACT_UNREG_DIR, 16'd6, 16'd0);
        send_word(pctt_pkg::ACT_RESET_DIR, 16'h8000, 16'd0);
        send_word(pctt_pkg::ACT_RESET_DIR, 16'd5, 16'd0);
    endtask

    task automatic test_random_mix(input int words);
        repeat (words) send_random_word(25, 24);
    endtask

    task automatic test_back_to_back(input int words);
        steady = 1'b1;
        repeat (words) send_random_word(25, 24);
        steady = 1'b0;
    endtask

    // register-heavy traffic over a wide id pool, so tables run full
    task automatic test_crowded_tables(input int words);
        repeat (words) send_random_word(45, 40);
    endtask

    initial begin
        for (int i = 0; i < 3 * SLOTS; i++) begin
            timer_handler[i] = '0;
            timer_period[i]  = '0;
            timer_count[i]   = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_refused_ids();
        test_period_rounding();
        test_shared_queued_id();
        test_random_mix(120);
        test_back_to_back(60);
        test_crowded_tables(130);
        test_random_mix(35);

        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d command and tick words, checked %0d result words (%0d timer fires)",
                 words_sent, words_checked, fires_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS periodic_callback_timer_table");
        else
            $display("FAIL periodic_callback_timer_table");
        $finish;
    end

endmodule

// ===== periodic_callback_timer_table.f =====
+incdir+rtl
rtl/pctt_pkg.sv
rtl/pctt_period.sv
rtl/periodic_callback_timer_table.sv
rtl/pctt_checker.sv
verif/tb_top.sv
